/* rtl/core/mbmf_pkg.sv */
package mbmf_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OUT_COLS = 3'd0,
        REG_OUT_ROWS = 3'd1,
        REG_WIN_ROWS = 3'd2,
        REG_WIN_COLS = 3'd3,
        REG_CHANNELS = 3'd4
    } t_reg_idx;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_STORE = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_NEXT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic store;
        logic clr;
        logic rd;
        logic acc;
        logic div_start;
        logic div_step;
        logic div_done;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last_tap;
        logic div_last;
    } t_sts;

endpackage

/* rtl/core/mbmf_ram.sv */
module mbmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/mbmf_ctrl.sv */
module mbmf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_fire,
    input  mbmf_pkg::t_sts  i_sts,
    output mbmf_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    mbmf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            mbmf_pkg::ST_IDLE: begin
                if (i_in_fire) n_state = mbmf_pkg::ST_STORE;
            end
            mbmf_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.clr = 1'b1;
                n_state = i_sts.emit ? mbmf_pkg::ST_RD : mbmf_pkg::ST_NEXT;
            end
            mbmf_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state = mbmf_pkg::ST_ACC;
            end
            mbmf_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = mbmf_pkg::ST_DIV;
                    o_cmd.div_start = 1'b1;
                end else begin
                    n_state = mbmf_pkg::ST_RD;
                end
            end
            mbmf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.div_done = 1'b1;
                    n_state = mbmf_pkg::ST_OUT;
                end
            end
            mbmf_pkg::ST_NEXT: begin
                n_state = mbmf_pkg::ST_IDLE;
            end
            mbmf_pkg::ST_OUT: begin
                if (i_out_fire) n_state = mbmf_pkg::ST_IDLE;
            end
            default: n_state = mbmf_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == mbmf_pkg::ST_IDLE);
    assign o_out_valid = (r_state == mbmf_pkg::ST_OUT);
endmodule

/* rtl/core/mbmf_dp.sv */
module mbmf_dp #(
    parameter int MAX_COLS    = 2048,
    parameter int MAX_WIN     = 15,
    parameter int CHANNELS    = 9,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mbmf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mbmf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_in_fire,
    input  logic [9*SAMPLE_BITS-1:0]             i_samples,
    input  logic                                 i_mask,
    input  mbmf_pkg::t_cmd                       i_cmd,
    output mbmf_pkg::t_sts                       o_sts,
    output logic [9*SAMPLE_BITS-1:0]             o_means,
    output logic                                 o_empty,
    output logic                                 o_last
);
    localparam int LINE_LEN = MAX_COLS + MAX_WIN - 1;
    localparam int CW = $clog2(LINE_LEN + 1);
    localparam int SW = $clog2(MAX_WIN);
    localparam int WW = $clog2(MAX_WIN + 1);
    localparam int DEPTH = MAX_WIN * LINE_LEN;
    localparam int AW = $clog2(DEPTH);
    localparam int MW = CHANNELS * SAMPLE_BITS + 1;
    localparam int NW = $clog2(MAX_WIN * MAX_WIN + 1);
    localparam int ACW = SAMPLE_BITS + NW + 1;
    localparam int DCW = $clog2(ACW + 1);

    logic [11:0] r_oc_reg;
    logic [15:0] r_or_reg;
    logic [3:0]  r_wr_reg, r_wc_reg, r_cu_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_reg <= 12'd2048;
            r_or_reg <= 16'd1024;
            r_wr_reg <= 4'd3;
            r_wc_reg <= 4'd3;
            r_cu_reg <= 4'd9;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbmf_pkg::REG_OUT_COLS: r_oc_reg <= i_cfg_data[11:0];
                mbmf_pkg::REG_OUT_ROWS: r_or_reg <= i_cfg_data;
                mbmf_pkg::REG_WIN_ROWS: r_wr_reg <= i_cfg_data[3:0];
                mbmf_pkg::REG_WIN_COLS: r_wc_reg <= i_cfg_data[3:0];
                mbmf_pkg::REG_CHANNELS: r_cu_reg <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] wr, wc;
    logic [CW-1:0] oc;
    logic [16:0]   orow;
    logic [CW-1:0] pad_cols;
    logic [17:0]   pad_rows;

    always_comb begin
        wr = (r_wr_reg == 4'd0) ? WW'(1) :
             (32'(r_wr_reg) > MAX_WIN) ? WW'(MAX_WIN) : WW'(r_wr_reg);
        wc = (r_wc_reg == 4'd0) ? WW'(1) :
             (32'(r_wc_reg) > MAX_WIN) ? WW'(MAX_WIN) : WW'(r_wc_reg);
        oc = (r_oc_reg == 12'd0) ? CW'(1) :
             (32'(r_oc_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(r_oc_reg);
        orow = (r_or_reg == 16'd0) ? 17'd1 : {1'b0, r_or_reg};
        pad_cols = oc + CW'(wc) - CW'(1);
        pad_rows = {1'b0, orow} + 18'(wr) - 18'd1;
    end

    logic [17:0]   r_row;
    logic [CW-1:0] r_col;
    logic [SW-1:0] r_slot;
    logic          r_last;
    logic          r_smask;
    logic [9*SAMPLE_BITS-1:0] r_samp;
    logic emit_c, last_c;

    assign emit_c = (r_row + 18'd1 >= 18'(wr)) && (r_col + CW'(1) >= CW'(wc));
    assign last_c = (r_row + 18'd1 >= pad_rows) && (r_col + CW'(1) >= pad_cols);

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_samp  <= i_samples;
            r_smask <= i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row <= '0; r_col <= '0; r_slot <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.store) begin
            r_last <= last_c;
            if (last_c) begin
                r_row <= '0; r_col <= '0; r_slot <= '0;
            end else if (r_col + CW'(1) >= pad_cols) begin
                r_row <= r_row + 18'd1; r_col <= '0;
                r_slot <= (32'(r_slot) == MAX_WIN - 1) ? '0 : r_slot + SW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // window tap walk: row i back from current slot, column j back
    logic [WW-1:0] r_ti, r_tj;
    logic [SW-1:0] r_ts;
    logic [CW-1:0] r_cur_col;
    logic          r_tap_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_ti <= '0; r_tj <= '0;
            r_ts <= r_slot;
            r_cur_col <= r_col;
        end else if (i_cmd.rd) begin
            r_tap_last <= (r_ti == wr - WW'(1)) && (r_tj == wc - WW'(1));
            if (r_tj == wc - WW'(1)) begin
                r_tj <= '0;
                r_ti <= r_ti + WW'(1);
                r_ts <= (r_ts == '0) ? SW'(MAX_WIN - 1) : r_ts - SW'(1);
            end else begin
                r_tj <= r_tj + WW'(1);
            end
        end
    end

    logic [AW-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;
    logic [CW-1:0] rcol;

    assign rcol  = r_cur_col - CW'(r_tj);
    assign waddr = AW'(r_slot) * AW'(LINE_LEN) + AW'(r_col);
    assign raddr = AW'(r_ts) * AW'(LINE_LEN) + AW'(rcol);
    assign wdata = {r_smask, r_samp[CHANNELS*SAMPLE_BITS-1:0]};

    mbmf_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_line (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic signed [ACW-1:0] r_sum [CHANNELS];
    logic signed [ACW-1:0] n_sum [CHANNELS];
    logic [NW-1:0]         r_cnt;

    always_comb begin
        for (int k = 0; k < CHANNELS; k++)
            n_sum[k] = rdata[MW-1] ?
                r_sum[k] + ACW'($signed(rdata[k*SAMPLE_BITS +: SAMPLE_BITS])) : r_sum[k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            for (int k = 0; k < CHANNELS; k++) r_sum[k] <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc && rdata[MW-1]) begin
            for (int k = 0; k < CHANNELS; k++)
                r_sum[k] <= n_sum[k];
            r_cnt <= r_cnt + NW'(1);
        end
    end

    // restoring division, one quotient bit per cycle, all channels in parallel
    logic [ACW-1:0] r_q [CHANNELS];
    logic [NW:0]    r_rem [CHANNELS];
    logic           r_neg [CHANNELS];
    logic [DCW-1:0] r_dcnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    // the last tap is added while the divider loads, so it loads the updated sum
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CHANNELS; k++) begin
            if (i_cmd.div_start) begin
                r_neg[k] <= n_sum[k][ACW-1];
                r_q[k]   <= n_sum[k][ACW-1] ? ACW'(-n_sum[k]) : ACW'(n_sum[k]);
                r_rem[k] <= '0;
            end else if (i_cmd.div_step) begin
                if ({r_rem[k][NW-1:0], r_q[k][ACW-1]} >= {1'b0, r_cnt}) begin
                    r_rem[k] <= {r_rem[k][NW-1:0], r_q[k][ACW-1]} - {1'b0, r_cnt};
                    r_q[k]   <= {r_q[k][ACW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k][NW-1:0], r_q[k][ACW-1]};
                    r_q[k]   <= {r_q[k][ACW-2:0], 1'b0};
                end
            end
        end
    end

    logic [ACW-1:0] qf [CHANNELS];
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            if ({r_rem[k][NW-1:0], r_q[k][ACW-1]} >= {1'b0, r_cnt})
                qf[k] = {r_q[k][ACW-2:0], 1'b1};
            else
                qf[k] = {r_q[k][ACW-2:0], 1'b0};
        end
    end

    logic [9*SAMPLE_BITS-1:0] r_means;
    logic r_empty, r_olast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_done) begin
            r_means <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                if (32'(k) < 32'(r_cu_reg) && r_cnt != '0)
                    r_means[k*SAMPLE_BITS +: SAMPLE_BITS] <=
                        r_neg[k] ? SAMPLE_BITS'(-qf[k]) : SAMPLE_BITS'(qf[k]);
            end
            r_empty <= (r_cnt == '0);
            r_olast <= r_last;
        end
    end

    assign o_sts.emit     = emit_c;
    assign o_sts.last_tap = r_tap_last;
    assign o_sts.div_last = (32'(r_dcnt) == ACW - 1);
    assign o_means = r_means;
    assign o_empty = r_empty;
    assign o_last  = r_olast;
endmodule

/* rtl/core/masked_boxcar_mean_filter_unit.sv */
// channel    dir  group     payload
// s_axis     in   i_s_axis  tdata: ch0..ch8 ; tuser: pixel_valid, edge_keep
// m_axis     out  o_m_axis  tdata: mean0..mean8 ; tuser: empty_window ; tlast: frame_end
// cfg        in   i_cfg     plain write: we, index, data
// One pixel at a time. A pixel that completes no window is only stored.
// A pixel that completes a window also takes one line-store read per window
// tap, then a 33-step bit-serial divider, then waits out any output stalls.
// Synchronous active-low reset; line store content is not cleared.
// Input is held off until the result transaction completes.
module masked_boxcar_mean_filter_unit #(
    parameter int MAX_COLS    = 2048,
    parameter int MAX_WIN     = 15,
    parameter int CHANNELS    = 9,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbmf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mbmf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ch0..ch8, lowest first
    input  logic [9*SAMPLE_BITS-1:0]            s_axis_tdata,
    // pixel_valid, edge_keep
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mean0..mean8, lowest first
    output logic [9*SAMPLE_BITS-1:0]            m_axis_tdata,
    // empty_window
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    mbmf_pkg::t_cmd cmd;
    mbmf_pkg::t_sts sts;
    logic in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    mbmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_fire (out_fire),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    mbmf_dp #(
        .MAX_COLS(MAX_COLS), .MAX_WIN(MAX_WIN),
        .CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_fire (in_fire),
        .i_samples (s_axis_tdata),
        .i_mask    (s_axis_tuser[0] & s_axis_tuser[1]),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_means   (m_axis_tdata),
        .o_empty   (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.div_done)) else $error("result without divide");
    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |=> s_axis_tready) else $error("not idle after result");
endmodule

/* verif/masked_boxcar_mean_filter_unit_tb.sv */
module masked_boxcar_mean_filter_unit_tb;

    localparam int SB       = 24;
    localparam int NCH      = 9;
    localparam int MAXC     = 2048;
    localparam int MAXW     = 15;
    localparam int LINE_LEN = MAXC + MAXW - 1;
    localparam int LIMIT    = 10000000;

    typedef struct {
        logic [SB-1:0] smp[NCH];
        bit            pix_ok;
        bit            keep;
    } t_pixel;

    typedef struct {
        logic [SB-1:0] mean[NCH];
        bit            empty;
        bit            last;
    } t_mean;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [mbmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [mbmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [NCH*SB-1:0]                  s_axis_tdata = '0;
    logic [1:0]                         s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [NCH*SB-1:0]                  m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               m_axis_tlast;

    masked_boxcar_mean_filter_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    // filter model state
    logic [SB-1:0] line_smp[MAXW][LINE_LEN][NCH];
    bit            line_msk[MAXW][LINE_LEN];
    int unsigned   reg_oc = 2048, reg_orow = 1024, reg_wr = 3, reg_wc = 3, reg_chu = 9;
    int unsigned   pos_row = 0, pos_col = 0;

    t_pixel pixel_queue[$];
    t_mean  mean_queue[$];
    t_pixel cur_px;
    int     idle_pct = 0, stall_pct = 0;
    int     errors = 0;
    int     cycles = 0;
    bit     took = 0;

    function automatic int unsigned clamp_sz(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic bit filter_pixel(t_pixel p, output t_mean m);
        int unsigned wr, wc, pc, pr, r, c, s, cnt;
        longint      sums[NCH];
        bit          emit, last;
        wr = clamp_sz(reg_wr, MAXW);
        wc = clamp_sz(reg_wc, MAXW);
        pc = clamp_sz(reg_oc, MAXC) + wc - 1;
        pr = clamp_sz(reg_orow, 65535) + wr - 1;
        r = pos_row;
        c = pos_col;
        for (int k = 0; k < NCH; k++) line_smp[r % MAXW][c][k] = p.smp[k];
        line_msk[r % MAXW][c] = p.pix_ok & p.keep;
        emit = (r + 1 >= wr) && (c + 1 >= wc);
        last = (r + 1 >= pr) && (c + 1 >= pc);
        if (emit) begin
            cnt = 0;
            for (int k = 0; k < NCH; k++) sums[k] = 0;
            for (int i = 0; i < wr; i++) begin
                s = (r - i) % MAXW;
                for (int j = 0; j < wc; j++) begin
                    if (line_msk[s][c-j]) begin
                        cnt++;
                        for (int k = 0; k < NCH; k++)
                            sums[k] += longint'($signed(line_smp[s][c-j][k]));
                    end
                end
            end
            for (int k = 0; k < NCH; k++)
                m.mean[k] = (k < reg_chu && cnt != 0) ? SB'(sums[k] / longint'(cnt)) : '0;
            m.empty = (cnt == 0);
            m.last = last;
        end
        if (last) begin
            pos_row = 0;
            pos_col = 0;
        end else if (c + 1 >= pc) begin
            pos_row = r + 1;
            pos_col = 0;
        end else begin
            pos_col = c + 1;
        end
        return emit;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        for (int k = 0; k < NCH; k++) begin
            case ($urandom_range(9))
                0: p.smp[k] = 24'h7FFFFF;
                1: p.smp[k] = 24'h800000;
                default: p.smp[k] = $urandom;
            endcase
        end
        p.pix_ok = ($urandom_range(3) != 0);
        p.keep = ($urandom_range(3) != 0);
        return p;
    endfunction

    // driver
    always @(negedge i_clk) begin
        logic [NCH*SB-1:0] td;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (!s_axis_tvalid || took) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_px = pixel_queue.pop_front();
                    for (int k = 0; k < NCH; k++) td[k*SB +: SB] = cur_px.smp[k];
                    s_axis_tdata <= td;
                    s_axis_tuser <= {cur_px.keep, cur_px.pix_ok};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // input acceptance and result check
    always @(posedge i_clk) begin
        t_pixel p;
        t_mean  m, e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("[masked_boxcar_mean_filter_unit] ERROR");
            $finish;
        end
        took = s_axis_tvalid && s_axis_tready && i_rst_n;
        if (took) begin
            for (int k = 0; k < NCH; k++) p.smp[k] = s_axis_tdata[k*SB +: SB];
            p.pix_ok = s_axis_tuser[0];
            p.keep = s_axis_tuser[1];
            if (filter_pixel(p, m)) mean_queue.push_back(m);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mean_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %h", $time,
                         m_axis_tdata);
            end else begin
                e = mean_queue.pop_front();
                for (int k = 0; k < NCH; k++)
                    if (m_axis_tdata[k*SB +: SB] !== e.mean[k]) begin
                        errors++;
                        $display("%0t: mean%0d expected %h actual %h", $time, k, e.mean[k],
                                 m_axis_tdata[k*SB +: SB]);
                    end
                if (m_axis_tuser !== e.empty) begin
                    errors++;
                    $display("%0t: empty_window expected %b actual %b", $time, e.empty,
                             m_axis_tuser);
                end
                if (m_axis_tlast !== e.last) begin
                    errors++;
                    $display("%0t: frame_end expected %b actual %b", $time, e.last,
                             m_axis_tlast);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || s_axis_tvalid || mean_queue.size() > 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(mbmf_pkg::t_reg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[mbmf_pkg::CFG_DATA_BITS-1:0];
        case (idx)
            mbmf_pkg::REG_OUT_COLS: reg_oc = val & 12'hFFF;
            mbmf_pkg::REG_OUT_ROWS: reg_orow = val & 16'hFFFF;
            mbmf_pkg::REG_WIN_ROWS: reg_wr = val & 4'hF;
            mbmf_pkg::REG_WIN_COLS: reg_wc = val & 4'hF;
            mbmf_pkg::REG_CHANNELS: reg_chu = val & 4'hF;
            default: ;
        endcase
        pos_row = 0;
        pos_col = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_block(int unsigned oc, int unsigned orow, int unsigned wr,
                             int unsigned wc, int unsigned chu, int n, int ph);
        int idle_tab[4]  = '{0, 64, 0, 34};
        int stall_tab[4] = '{0, 0, 64, 34};
        wait_idle();
        write_reg(mbmf_pkg::REG_OUT_COLS, oc);
        write_reg(mbmf_pkg::REG_OUT_ROWS, orow);
        write_reg(mbmf_pkg::REG_WIN_ROWS, wr);
        write_reg(mbmf_pkg::REG_WIN_COLS, wc);
        write_reg(mbmf_pkg::REG_CHANNELS, chu);
        idle_pct = idle_tab[ph % 4];
        stall_pct = stall_tab[ph % 4];
        for (int i = 0; i < n; i++) pixel_queue.push_back(rand_pixel());
    endtask

    initial begin
        t_pixel p;
        int     sent, ph, oc, orow, wr, wc, n;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale samples, masked pixels, empty windows
        run_block(3, 2, 3, 3, 9, 0, 0);
        for (int i = 0; i < 20; i++) begin
            for (int k = 0; k < NCH; k++) p.smp[k] = (i < 10) ? 24'h7FFFFF : 24'h800000;
            p.pix_ok = (i != 7);
            p.keep = (i != 12);
            pixel_queue.push_back(p);
        end
        run_block(1, 1, 1, 1, 9, 0, 0);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < NCH; k++) p.smp[k] = 24'h800000;
            p.pix_ok = i[0];
            p.keep = i[1];
            pixel_queue.push_back(p);
        end

        run_block(5, 4, 3, 3, 9, 126, 0);
        run_block(1, 1, 1, 1, 9, 60, 1);
        run_block(0, 0, 0, 0, 0, 40, 2);
        run_block(8, 3, 5, 2, 4, 189, 3);
        run_block(2, 1, 15, 15, 15, 240, 0);
        run_block(4095, 65535, 1, 2, 9, 100, 1);
        run_block(2048, 2, 1, 3, 10, 150, 2);
        run_block(16, 5, 3, 5, 9, 280, 3);
        sent = 1209;
        ph = 0;
        while (sent < 1900) begin
            oc = $urandom_range(12, 1);
            orow = $urandom_range(6, 1);
            wr = $urandom_range(5, 1);
            wc = $urandom_range(5, 1);
            n = (oc + wc - 1) * (orow + wr - 1) * $urandom_range(2, 1)
                + $urandom_range(5);
            run_block(oc, orow, wr, wc, $urandom_range(15), n, ph);
            sent += n;
            ph++;
        end

        wait_idle();
        repeat (600) @(negedge i_clk);
        if (errors == 0 && mean_queue.size() == 0)
            $display("[masked_boxcar_mean_filter_unit] OK");
        else
            $display("[masked_boxcar_mean_filter_unit] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mbmf_pkg.sv
rtl/core/mbmf_ram.sv
rtl/core/mbmf_ctrl.sv
rtl/core/mbmf_dp.sv
rtl/core/masked_boxcar_mean_filter_unit.sv
verif/masked_boxcar_mean_filter_unit_tb.sv
